/* rtl/slot_pool_allocator_macros.svh */
// Assertion macros for the slot pool allocator
`ifndef SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/spa_pkg.sv */
package spa_pkg;

  // Pool geometry
  localparam int POOL_SLOTS = 1024;
  localparam int ADDR_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

  // Field widths on the stream ports
  localparam int SLOT_W     = 10;
  localparam int COUNT_FW   = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_POOL_EMPTY  = 2'd1,
    ST_NOT_IN_USE  = 2'd2,
    ST_BAD_INDEX   = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep_start;
    logic sweep;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic sweep_last;
  } dp_stat_t;

endpackage

/* rtl/spa_ram.sv */
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/spa_ctrl.sv */
`include "slot_pool_allocator_macros.svh"

module spa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  spa_pkg::cmd_t     in_cmd,
  input  spa_pkg::dp_stat_t stat,
  output spa_pkg::ctrl_cmd_t cmd
);

  import spa_pkg::*;

  typedef enum logic [1:0] {
    SWEEP_RST,
    IDLE,
    EXEC,
    SWEEP_CLR
  } state_t;

  state_t state;

  // Decode commands to the datapath
  always_comb begin
    s_tready        = (state == IDLE);
    cmd.accept      = s_tvalid && s_tready;
    cmd.sweep_start = cmd.accept && (in_cmd == CMD_CLEAR);
    cmd.sweep       = (state == SWEEP_RST) || (state == SWEEP_CLR);
    cmd.commit      = (state == EXEC) && stat.out_free;
  end

  // Sequence: sweep after reset, then accept, execute, or sweep for a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SWEEP_RST;
    end else begin
      case (state)
        SWEEP_RST: begin
          if (stat.sweep_last) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (cmd.sweep_start) begin
            state <= SWEEP_CLR;
          end else if (cmd.accept) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        SWEEP_CLR: begin
          if (stat.sweep_last) begin
            state <= EXEC;
          end
        end
        default: begin
          state <= SWEEP_RST;
        end
      endcase
    end
  end

  `SPA_ASSERT_IMPL(a_no_accept_in_sweep, clk, rst, cmd.sweep, !s_tready, "accept during sweep")
  `SPA_ASSERT_NEXT(a_clear_sweeps, clk, rst, cmd.sweep_start, (state == SWEEP_CLR), "clear without sweep")
  `SPA_ASSERT_IMPL(a_one_action, clk, rst, 1'b1, ($onehot0({cmd.accept, cmd.sweep, cmd.commit})), "overlapping actions")

endmodule

/* rtl/spa_dp.sv */
`include "slot_pool_allocator_macros.svh"

module spa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  spa_pkg::ctrl_cmd_t                cmd,
  output spa_pkg::dp_stat_t                 stat,
  input  spa_pkg::cmd_t                     in_cmd,
  input  logic [spa_pkg::SLOT_W-1:0]        in_slot,
  input  logic [spa_pkg::SLOT_W-1:0]        in_idx,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [spa_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                        m_tuser
);

  import spa_pkg::*;

  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);

  // Control state
  logic [CNT_W-1:0]  ac;
  logic [CNT_W-1:0]  ac_next;
  logic [ADDR_W-1:0] sweep_cnt;

  // Captured item
  cmd_t              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] idx_q;
  logic              slot_ok_q;
  logic              idx_ok_q;

  // Memory ports
  logic              free_we, list_we, pos_we, busy_we;
  logic [ADDR_W-1:0] free_waddr, list_waddr, pos_waddr, busy_waddr;
  logic [ADDR_W-1:0] free_wdata, list_wdata, pos_wdata;
  logic              busy_wdata;
  logic [ADDR_W-1:0] free_raddr, list_raddr, slot_raddr;
  logic [ADDR_W-1:0] free_rdata, list_rdata, pos_rdata;
  logic              busy_rdata;

  // Result
  logic              alloc_ok, rel_ok;
  logic [SLOT_W-1:0] r_slot, r_pos;
  status_t           r_status;
  logic [SLOT_W-1:0] out_slot, out_pos;
  logic [COUNT_FW-1:0] out_count;
  status_t           out_status;

  assign stat.out_free   = !m_tvalid || m_tready;
  assign stat.sweep_last = (sweep_cnt == ADDR_W'(POOL_SLOTS - 1));

  // Read addresses, issued in the accept cycle
  assign free_raddr = ADDR_W'(POOL_CNT - ac - CNT_W'(1));
  assign list_raddr = (in_cmd == CMD_READ) ? ADDR_W'(in_idx) : ADDR_W'(ac - CNT_W'(1));
  assign slot_raddr = ADDR_W'(in_slot);

  spa_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_SLOTS)) u_free_stack (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .re(cmd.accept), .raddr(free_raddr), .rdata(free_rdata)
  );

  spa_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_SLOTS)) u_active_list (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .re(cmd.accept), .raddr(list_raddr), .rdata(list_rdata)
  );

  spa_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_SLOTS)) u_position (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .re(cmd.accept), .raddr(slot_raddr), .rdata(pos_rdata)
  );

  spa_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_busy (
    .clk(clk), .we(busy_we), .waddr(busy_waddr), .wdata(busy_wdata),
    .re(cmd.accept), .raddr(slot_raddr), .rdata(busy_rdata)
  );

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q     <= in_cmd;
      slot_q    <= in_slot;
      idx_q     <= in_idx;
      slot_ok_q <= (32'(in_slot) < POOL_SLOTS);
      idx_ok_q  <= (32'(in_idx) < 32'(ac)) && (32'(in_idx) < POOL_SLOTS);
    end
  end

  assign alloc_ok = (ac < POOL_CNT);
  assign rel_ok   = slot_ok_q && busy_rdata && (ac != '0);

  // Write-back and count update
  always_comb begin
    free_we    = 1'b0;
    free_waddr = sweep_cnt;
    free_wdata = sweep_cnt;
    list_we    = 1'b0;
    list_waddr = ADDR_W'(ac);
    list_wdata = free_rdata;
    pos_we     = 1'b0;
    pos_waddr  = free_rdata;
    pos_wdata  = ADDR_W'(ac);
    busy_we    = 1'b0;
    busy_waddr = sweep_cnt;
    busy_wdata = 1'b0;
    ac_next    = ac;
    if (cmd.sweep_start) begin
      ac_next = '0;
    end else if (cmd.sweep) begin
      // Refill the free stack in identity order and mark every slot idle
      free_we = 1'b1;
      busy_we = 1'b1;
    end else if (cmd.commit) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (alloc_ok) begin
            list_we    = 1'b1;
            pos_we     = 1'b1;
            busy_we    = 1'b1;
            busy_waddr = free_rdata;
            busy_wdata = 1'b1;
            ac_next    = ac + CNT_W'(1);
          end
        end
        CMD_RELEASE: begin
          if (rel_ok) begin
            // Push the slot and move the last active entry into its place
            free_we    = 1'b1;
            free_waddr = ADDR_W'(POOL_CNT - ac);
            free_wdata = ADDR_W'(slot_q);
            busy_we    = 1'b1;
            busy_waddr = ADDR_W'(slot_q);
            list_we    = 1'b1;
            list_waddr = pos_rdata;
            list_wdata = list_rdata;
            pos_we     = 1'b1;
            pos_waddr  = list_rdata;
            pos_wdata  = pos_rdata;
            ac_next    = ac - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Form the result
  always_comb begin
    r_slot   = '0;
    r_pos    = '0;
    r_status = ST_OK;
    case (cmd_q)
      CMD_ALLOC: begin
        if (alloc_ok) begin
          r_slot = SLOT_W'(free_rdata);
          r_pos  = SLOT_W'(ac);
        end else begin
          r_status = ST_POOL_EMPTY;
        end
      end
      CMD_RELEASE: begin
        r_slot = slot_q;
        if (rel_ok) begin
          r_pos = SLOT_W'(pos_rdata);
        end else begin
          r_status = ST_NOT_IN_USE;
        end
      end
      CMD_READ: begin
        if (idx_ok_q) begin
          r_slot = SLOT_W'(list_rdata);
          r_pos  = idx_q;
        end else begin
          r_status = ST_BAD_INDEX;
        end
      end
      CMD_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  // Count and sweep registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ac        <= '0;
      sweep_cnt <= '0;
    end else begin
      ac <= ac_next;
      if (cmd.sweep_start) begin
        sweep_cnt <= '0;
      end else if (cmd.sweep) begin
        sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + ADDR_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot   <= r_slot;
      out_pos    <= r_pos;
      out_count  <= COUNT_FW'(ac_next);
      out_status <= r_status;
    end
  end

  assign m_tdata = {1'b0, out_count, out_pos, out_slot};
  assign m_tuser = out_status;

  `SPA_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, (ac <= POOL_CNT), "in-use count above pool size")
  `SPA_ASSERT_IMPL(a_commit_free, clk, rst, cmd.commit, stat.out_free, "result over a waiting one")
  `SPA_ASSERT_NEXT(a_alloc_count, clk, rst, (cmd.commit && cmd_q == CMD_ALLOC && alloc_ok), (ac == $past(ac) + CNT_W'(1)), "allocate did not count")

endmodule

/* rtl/slot_pool_allocator.sv */
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: command[1:0]; tdata: slot_number[9:0], list_index[19:10]
// m_axis    out  tuser: status[1:0]; tdata: result_slot[9:0], result_position[19:10],
//                in_use_count[30:20]
//
// Allocate, release and read: the transfer cycle reads the free stack, active list,
// position and busy memories, then the EXEC state writes them back and loads the
// output register once it is free. Clear sweeps one entry a cycle through the free
// stack and busy memories, then loads the output register in EXEC.
// After reset the same sweep runs with s_tready low.
// A result waiting in the output register holds back the next write-back only.
module slot_pool_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [spa_pkg::IN_DATA_W-1:0]  s_tdata,  // slot_number, list_index
  input  logic [1:0]                     s_tuser,  // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spa_pkg::OUT_DATA_W-1:0] m_tdata,  // result_slot, result_position, in_use_count
  output logic [1:0]                     m_tuser   // status
);

  import spa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  cmd_t      in_cmd;

  assign in_cmd = cmd_t'(s_tuser);

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  spa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_cmd   (in_cmd),
    .in_slot  (s_tdata[SLOT_W-1:0]),
    .in_idx   (s_tdata[2*SLOT_W-1:SLOT_W]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* bench/tb_slot_pool_allocator.sv */
module tb_slot_pool_allocator;
  import spa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int FULL_DWELL   = 40;

  // One predicted transfer on the result side
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   position;
    logic [COUNT_FW-1:0] count;
    status_t             status;
  } pool_result_t;

  // Shadow of the pool: free stack, dense active list and per-slot bookkeeping
  class slot_pool_tracker;
    logic [SLOT_W-1:0] free_stack [POOL_SLOTS];
    logic [SLOT_W-1:0] active_list [POOL_SLOTS];
    logic [SLOT_W-1:0] position_of [POOL_SLOTS];
    bit                busy [POOL_SLOTS];
    int unsigned       free_count;
    int unsigned       in_use;
    pool_result_t      pending_results [$];
    int unsigned       mismatches;

    function void refill();
      for (int i = 0; i < POOL_SLOTS; i++) begin
        free_stack[i] = SLOT_W'(i);
        busy[i] = 1'b0;
      end
      free_count = POOL_SLOTS;
      in_use = 0;
    endfunction

    function void power_up();
      for (int i = 0; i < POOL_SLOTS; i++) begin
        active_list[i] = '0;
        position_of[i] = '0;
      end
      mismatches = 0;
      refill();
    endfunction

    // Advance the shadow by one accepted command and queue its result
    function void note_command(cmd_t cmd, logic [SLOT_W-1:0] slot_no,
                               logic [SLOT_W-1:0] index);
      pool_result_t r;
      logic [SLOT_W-1:0] s;
      logic [SLOT_W-1:0] pos;
      logic [SLOT_W-1:0] moved;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_ALLOC: begin
          if (free_count == 0 || in_use >= POOL_SLOTS) begin
            r.status = ST_POOL_EMPTY;
          end else begin
            free_count--;
            s = free_stack[free_count];
            active_list[in_use] = s;
            position_of[s] = SLOT_W'(in_use);
            busy[s] = 1'b1;
            r.slot = s;
            r.position = SLOT_W'(in_use);
            in_use++;
          end
        end
        CMD_RELEASE: begin
          r.slot = slot_no;
          if (!busy[slot_no] || in_use == 0 || free_count >= POOL_SLOTS) begin
            r.status = ST_NOT_IN_USE;
          end else begin
            pos = position_of[slot_no];
            free_stack[free_count] = slot_no;
            free_count++;
            busy[slot_no] = 1'b0;
            in_use--;
            moved = active_list[in_use];
            active_list[pos] = moved;
            position_of[moved] = pos;
            r.position = pos;
          end
        end
        CMD_READ: begin
          if (index >= in_use) begin
            r.status = ST_BAD_INDEX;
          end else begin
            r.slot = active_list[index];
            r.position = index;
          end
        end
        default: refill();
      endcase
      r.count = COUNT_FW'(in_use);
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic [OUT_DATA_W-1:0] data, logic [1:0] user);
      pool_result_t want;
      pool_result_t got;
      got.slot     = data[9:0];
      got.position = data[19:10];
      got.count    = data[30:20];
      got.status   = status_t'(user);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: slot %0d pos %0d count %0d status %0d",
                   got.slot, got.position, got.count, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected slot %0d pos %0d count %0d status %0d, got %0d %0d %0d %0d",
                   want.slot, want.position, want.count, want.status,
                   got.slot, got.position, got.count, got.status);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;

  slot_pool_tracker tracker = new;
  int unsigned sender_idle   = 10;
  int unsigned receiver_idle = 61;
  bit          filling       = 1'b1;
  int unsigned full_items    = 0;
  int unsigned cycle_count   = 0;

  slot_pool_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Hold the command until the transfer, then advance the shadow
  task automatic send_item(input cmd_t cmd, input logic [SLOT_W-1:0] slot_no,
                           input logic [SLOT_W-1:0] index);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'd0, index, slot_no};
    do @(posedge clk); while (!s_tready);
    tracker.note_command(cmd, slot_no, index);
  endtask

  // Stop sending until every predicted result has been taken
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  // Draw one random command: fill the pool first, then a broad mix
  task automatic pick_command(output cmd_t cmd, output logic [SLOT_W-1:0] slot_no,
                              output logic [SLOT_W-1:0] index);
    int unsigned roll;
    int unsigned busy_cut;
    int unsigned stray_cut;
    int unsigned read_cut;
    int unsigned wide_read_cut;
    roll    = $urandom_range(99);
    slot_no = SLOT_W'($urandom_range(POOL_SLOTS - 1));
    index   = SLOT_W'($urandom_range(1023));
    if (filling) begin
      busy_cut = 92; stray_cut = 94; read_cut = 97; wide_read_cut = 100;
    end else begin
      busy_cut = 70; stray_cut = 75; read_cut = 88; wide_read_cut = 99;
    end
    if (roll < (filling ? 88 : 40)) begin
      cmd = CMD_ALLOC;
    end else if (roll < busy_cut) begin
      cmd = CMD_RELEASE;
      if (tracker.in_use != 0)
        slot_no = tracker.active_list[$urandom_range(tracker.in_use - 1)];
    end else if (roll < stray_cut) begin
      cmd = CMD_RELEASE;
    end else if (roll < read_cut) begin
      cmd = CMD_READ;
      index = (tracker.in_use != 0) ? SLOT_W'($urandom_range(tracker.in_use - 1)) : '0;
    end else if (roll < wide_read_cut) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_CLEAR;
    end
  endtask

  // Accept results, stalling at the current rate
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  // Give up once the cycle budget is spent
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_slot_pool_allocator: done, errors");
    $finish;
  end

  initial begin
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot_no;
    logic [SLOT_W-1:0] index;
    tracker.power_up();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list reads, idle releases, swap on release, clear
    send_item(CMD_READ, 10'd0, 10'd0);
    send_item(CMD_READ, 10'd0, 10'd1023);
    send_item(CMD_RELEASE, 10'd0, 10'd0);
    send_item(CMD_RELEASE, 10'd1023, 10'd1023);
    send_item(CMD_ALLOC, 10'd0, 10'd0);
    send_item(CMD_ALLOC, 10'd1023, 10'd1023);
    send_item(CMD_ALLOC, 10'd0, 10'd0);
    send_item(CMD_READ, 10'd0, 10'd0);
    send_item(CMD_READ, 10'd0, 10'd2);
    send_item(CMD_READ, 10'd0, 10'd3);
    send_item(CMD_RELEASE, 10'd1023, 10'd0);
    send_item(CMD_READ, 10'd0, 10'd0);
    send_item(CMD_RELEASE, 10'd1023, 10'd0);
    send_item(CMD_ALLOC, 10'd0, 10'd0);
    send_item(CMD_RELEASE, 10'd1023, 10'd0);
    send_item(CMD_RELEASE, 10'd1022, 10'd0);
    send_item(CMD_CLEAR, 10'd1023, 10'd1023);
    send_item(CMD_READ, 10'd0, 10'd0);
    send_item(CMD_RELEASE, 10'd1021, 10'd0);
    send_item(CMD_ALLOC, 10'd0, 10'd0);
    send_item(CMD_RELEASE, 10'd1023, 10'd0);
    send_item(CMD_READ, 10'd0, 10'd1023);
    wait_for_results();

    // Random: sender light, receiver heavy; then swapped; then no idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_for_results();
        sender_idle = 61;
        receiver_idle = 10;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_for_results();
        sender_idle = 0;
        receiver_idle = 0;
      end else if ($urandom_range(99) == 0) begin
        wait_for_results();
      end
      pick_command(cmd, slot_no, index);
      send_item(cmd, slot_no, index);
      if (filling && tracker.in_use == POOL_SLOTS) full_items++;
      if (full_items >= FULL_DWELL) filling = 1'b0;
    end

    // Drain, then watch for stray results
    wait_for_results();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("tb_slot_pool_allocator: done, clean");
    else
      $display("tb_slot_pool_allocator: done, errors");
    $finish;
  end

endmodule
